@@ design/srss_pkg.sv @@
// srss_pkg: shared types and fixed constants of the surface reaction SSA step.
// Request payload structs for the input and result channels.
// No dependencies.
package srss_pkg;

  localparam int COUNT_BITS     = 20;
  localparam int TIME_FRAC_BITS = 24;
  localparam int LN_TABLE_BITS  = 10;
  localparam int COEF_BITS      = 32;
  localparam int TIME_BITS      = 48;
  localparam int MOL_BITS       = 32;
  localparam int DRAW_BITS      = 32;
  localparam int RXN_BITS       = 3;
  localparam int NUM_COEF       = 7;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 48;

  localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_TIME = 4'd7;

  localparam logic [RXN_BITS-1:0] RXN_NONE = 3'd0;
  localparam logic [RXN_BITS-1:0] RXN_FA   = 3'd1;
  localparam logic [RXN_BITS-1:0] RXN_FD   = 3'd2;
  localparam logic [RXN_BITS-1:0] RXN_SA   = 3'd3;
  localparam logic [RXN_BITS-1:0] RXN_ER   = 3'd4;
  localparam logic [RXN_BITS-1:0] RXN_DS   = 3'd5;
  localparam logic [RXN_BITS-1:0] RXN_LHS  = 3'd6;
  localparam logic [RXN_BITS-1:0] RXN_LHF  = 3'd7;

  typedef struct packed {
    logic                  restart;
    logic [COUNT_BITS-1:0] initial_free_vacancies;
    logic [COUNT_BITS-1:0] initial_strong_vacancies;
    logic [MOL_BITS-1:0]   initial_molecules;
    logic [DRAW_BITS-1:0]  uniform_time;
    logic [DRAW_BITS-1:0]  uniform_choice;
  } in_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  sim_time;
    logic [COUNT_BITS-1:0] free_vacancies;
    logic [COUNT_BITS-1:0] free_adsorbed;
    logic [COUNT_BITS-1:0] strong_vacancies;
    logic [COUNT_BITS-1:0] strong_adsorbed;
    logic [MOL_BITS-1:0]   molecules;
    logic [RXN_BITS-1:0]   reaction;
    logic                  finished;
  } out_item_t;

endpackage

@@ design/surface_reaction_ssa_step.sv @@
// surface_reaction_ssa_step: one Gillespie direct-method step over a bit-serial
// shift-add multiplier, a serial normaliser and a restoring divider.
// Depends on srss_pkg.
//
//   channel | ports                        | moves
//   --------+------------------------------+--------------------------------
//   input   | in_valid, in_ready, in_data  | one step or restart request
//   result  | out_valid, out_ready, out_data | state after the request
//   config  | cfg_we, cfg_index, cfg_data  | coefficient or stop time write
//
// Restart, finished and time-limit requests go straight to the result state. A full
// step's length is set mostly by the shared 1-bit-per-cycle multiplier: up to 10
// propensity products, 32 squarings for the log table entry, 4 products for ln and
// threshold, plus the serial normalise and divide loops. One request is worked at a
// time; the result register lets the next request in while a result waits. Reset
// is synchronous, active low.
module surface_reaction_ssa_step (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  srss_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output srss_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [srss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [srss_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int CB        = srss_pkg::COUNT_BITS;
  localparam int TB        = srss_pkg::TIME_BITS;
  localparam int MB        = srss_pkg::MOL_BITS;
  localparam int LB        = srss_pkg::LN_TABLE_BITS;
  localparam int PROP_BITS = 60;
  localparam int TOT_BITS  = 63;
  localparam int ACC_BITS  = 72;
  localparam int MP_BITS   = 32;
  localparam int NLN_BITS  = 38;
  localparam int DVD_BITS  = NLN_BITS + 16;
  localparam int REM_BITS  = 64;
  localparam int DT_SHIFT  = 32 - srss_pkg::TIME_FRAC_BITS;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [ACC_BITS-1:0] PROP_MAX = {{(ACC_BITS-PROP_BITS){1'b0}}, {PROP_BITS{1'b1}}};
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [MB-1:0] MOL_MAX = {MB{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE, S_PROP_A, S_PROP_B, S_PROP_C, S_PROP_END, S_NORM, S_SQ,
    S_LN_A, S_LN_B, S_LN_C, S_DIV, S_TIME, S_THR_A, S_THR_B, S_CHOOSE,
    S_APPLY, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] coef_r [srss_pkg::NUM_COEF];
  logic [31:0] coef_nxt [srss_pkg::NUM_COEF];
  logic [TB-1:0] stop_r, stop_nxt;
  logic [CB-1:0] fv_r, fv_nxt, af_r, af_nxt, sv_r, sv_nxt, as_r, as_nxt;
  logic [MB-1:0] mol_r, mol_nxt;
  logic [TB-1:0] time_r, time_nxt;
  logic done_r, done_nxt;
  logic [31:0] ut_r, ut_nxt, uc_r, uc_nxt;
  logic [2:0] j_r, j_nxt;
  logic [PROP_BITS-1:0] r_r [7];
  logic [PROP_BITS-1:0] r_nxt [7];
  logic [TOT_BITS-1:0] total_r, total_nxt;
  logic [ACC_BITS-1:0] mc_r, mc_nxt, acc_r, acc_nxt;
  logic [MP_BITS-1:0] mp_r, mp_nxt;
  logic [5:0] mcnt_r, mcnt_nxt;
  logic mrun_r, mrun_nxt;
  logic [31:0] mn_r, mn_nxt, lg_r, lg_nxt;
  logic [4:0] sh_r, sh_nxt;
  logic [5:0] it_r, it_nxt;
  logic [63:0] tmp_r, tmp_nxt, cum_r, cum_nxt;
  logic [DVD_BITS-1:0] dq_r, dq_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [2:0] rxn_r, rxn_nxt;
  srss_pkg::out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [CB-1:0] a_sel, b_sel;
  logic [PROP_BITS-1:0] prop_sat, prop_dsc;
  logic [PROP_BITS+1:0] prop_x3;
  logic [NLN_BITS-1:0] n2;
  logic [REM_BITS-1:0] rem_s;
  logic rem_ge;
  logic [TB:0] time_sum;
  logic [32:0] sq_y;
  logic [63:0] cum_s;

  function automatic logic [CB-1:0] inc_cnt(input logic [CB-1:0] v, input logic [1:0] k);
    logic [CB:0] s;
    s = {1'b0, v} + {{(CB-1){1'b0}}, k};
    inc_cnt = (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CB-1:0];
  endfunction

  function automatic logic [MB-1:0] inc_mol(input logic [MB-1:0] v);
    inc_mol = (v == MOL_MAX) ? MOL_MAX : v + MB'(1);
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    a_sel = fv_r;
    b_sel = af_r;
    case (j_r)
      3'd0: a_sel = fv_r;
      3'd1: a_sel = af_r;
      3'd2: a_sel = sv_r;
      3'd3: a_sel = as_r;
      3'd4: begin a_sel = af_r; b_sel = sv_r; end
      3'd5: begin a_sel = af_r; b_sel = as_r; end
      default: begin a_sel = af_r; b_sel = af_r; end
    endcase
  end

  assign prop_sat = (acc_r > PROP_MAX) ? PROP_MAX[PROP_BITS-1:0] : acc_r[PROP_BITS-1:0];
  assign prop_x3  = {2'b00, prop_sat} + {1'b0, prop_sat, 1'b0};
  assign prop_dsc = prop_x3[PROP_BITS+1:2];
  assign n2       = {6'({1'b0, sh_r}) + 6'd1, 32'd0} - {6'd0, lg_r};
  assign rem_s    = {rem_r[REM_BITS-2:0], dq_r[DVD_BITS-1]};
  assign rem_ge   = rem_s >= {1'b0, total_r};
  assign time_sum = (TB+1)'(time_r) + (TB+1)'(dq_r >> DT_SHIFT);
  assign sq_y     = acc_r[63:31];
  assign cum_s    = cum_r + {4'd0, r_r[0]};

  always_comb begin
    state_nxt = state_r;
    coef_nxt  = coef_r;
    stop_nxt  = stop_r;
    fv_nxt = fv_r; af_nxt = af_r; sv_nxt = sv_r; as_nxt = as_r;
    mol_nxt = mol_r; time_nxt = time_r; done_nxt = done_r;
    ut_nxt = ut_r; uc_nxt = uc_r; j_nxt = j_r; r_nxt = r_r; total_nxt = total_r;
    mc_nxt = mc_r; acc_nxt = acc_r; mp_nxt = mp_r; mcnt_nxt = mcnt_r; mrun_nxt = mrun_r;
    mn_nxt = mn_r; lg_nxt = lg_r; sh_nxt = sh_r; it_nxt = it_r;
    tmp_nxt = tmp_r; cum_nxt = cum_r; dq_nxt = dq_r; rem_nxt = rem_r; rxn_nxt = rxn_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_we) begin
      if (cfg_index < srss_pkg::CFG_INDEX_BITS'(srss_pkg::NUM_COEF)) begin
        coef_nxt[cfg_index[2:0]] = cfg_data[31:0];
      end else if (cfg_index == srss_pkg::REG_STOP_TIME) begin
        stop_nxt = cfg_data[TB-1:0];
      end
    end

    // advance the serial multiplier
    if (mrun_r) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt   = mc_r << 1;
      mp_nxt   = mp_r >> 1;
      mcnt_nxt = mcnt_r - 6'd1;
      if (mcnt_r == 6'd1) mrun_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ut_nxt  = in_data.uniform_time;
          uc_nxt  = in_data.uniform_choice;
          rxn_nxt = srss_pkg::RXN_NONE;
          if (in_data.restart) begin
            fv_nxt   = in_data.initial_free_vacancies;
            sv_nxt   = in_data.initial_strong_vacancies;
            af_nxt   = '0;
            as_nxt   = '0;
            mol_nxt  = in_data.initial_molecules;
            time_nxt = '0;
            done_nxt = (stop_r == '0);
            state_nxt = S_OUT;
          end else if (done_r) begin
            state_nxt = S_OUT;
          end else if (time_r >= stop_r) begin
            done_nxt  = 1'b1;
            state_nxt = S_OUT;
          end else begin
            j_nxt     = 3'd0;
            total_nxt = '0;
            state_nxt = S_PROP_A;
          end
        end
      end
      S_PROP_A: begin
        if (j_r == 3'd6 && af_r < CB'(2)) begin
          for (int i = 0; i < 6; i++) r_nxt[i] = r_r[i+1];
          r_nxt[6]  = '0;
          state_nxt = S_PROP_END;
        end else begin
          acc_nxt   = '0;
          mc_nxt    = ACC_BITS'(coef_r[j_r]);
          mp_nxt    = MP_BITS'(a_sel);
          mcnt_nxt  = 6'(MP_BITS);
          mrun_nxt  = 1'b1;
          state_nxt = S_PROP_B;
        end
      end
      S_PROP_B: begin
        if (!mrun_r) begin
          if (j_r >= 3'd4) begin
            acc_nxt   = '0;
            mc_nxt    = acc_r;
            mp_nxt    = MP_BITS'(b_sel);
            mcnt_nxt  = 6'(MP_BITS);
            mrun_nxt  = 1'b1;
            state_nxt = S_PROP_C;
          end else begin
            for (int i = 0; i < 6; i++) r_nxt[i] = r_r[i+1];
            r_nxt[6]  = acc_r[PROP_BITS-1:0];
            total_nxt = total_r + TOT_BITS'(acc_r[PROP_BITS-1:0]);
            j_nxt     = j_r + 3'd1;
            state_nxt = S_PROP_A;
          end
        end
      end
      S_PROP_C: begin
        if (!mrun_r) begin
          for (int i = 0; i < 6; i++) r_nxt[i] = r_r[i+1];
          if (j_r == 3'd4) begin
            r_nxt[6]  = prop_dsc;
            total_nxt = total_r + TOT_BITS'(prop_dsc);
          end else begin
            r_nxt[6]  = prop_sat;
            total_nxt = total_r + TOT_BITS'(prop_sat);
          end
          if (j_r == 3'd6) begin
            state_nxt = S_PROP_END;
          end else begin
            j_nxt     = j_r + 3'd1;
            state_nxt = S_PROP_A;
          end
        end
      end
      S_PROP_END: begin
        if (total_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          mn_nxt    = (ut_r == '0) ? 32'd1 : ut_r;
          sh_nxt    = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (mn_r[31]) begin
          lg_nxt    = '0;
          it_nxt    = '0;
          acc_nxt   = '0;
          mc_nxt    = ACC_BITS'({mn_r[31:31-LB], {(31-LB){1'b0}}});
          mp_nxt    = {mn_r[31:31-LB], {(31-LB){1'b0}}};
          mcnt_nxt  = 6'(MP_BITS);
          mrun_nxt  = 1'b1;
          state_nxt = S_SQ;
        end else begin
          mn_nxt = mn_r << 1;
          sh_nxt = sh_r + 5'd1;
        end
      end
      S_SQ: begin
        if (!mrun_r) begin
          lg_nxt = {lg_r[30:0], sq_y[32]};
          it_nxt = it_r + 6'd1;
          if (it_r == 6'd31) begin
            state_nxt = S_LN_A;
          end else begin
            acc_nxt  = '0;
            mc_nxt   = ACC_BITS'(sq_y[32] ? sq_y[32:1] : sq_y[31:0]);
            mp_nxt   = sq_y[32] ? sq_y[32:1] : sq_y[31:0];
            mcnt_nxt = 6'(MP_BITS);
            mrun_nxt = 1'b1;
          end
        end
      end
      S_LN_A: begin
        acc_nxt   = '0;
        mc_nxt    = ACC_BITS'(LN2_Q32);
        mp_nxt    = n2[31:0];
        mcnt_nxt  = 6'(MP_BITS);
        mrun_nxt  = 1'b1;
        state_nxt = S_LN_B;
      end
      S_LN_B: begin
        if (!mrun_r) begin
          tmp_nxt   = {32'd0, acc_r[63:32]};
          acc_nxt   = '0;
          mc_nxt    = ACC_BITS'(LN2_Q32);
          mp_nxt    = MP_BITS'(n2[NLN_BITS-1:32]);
          mcnt_nxt  = 6'(MP_BITS);
          mrun_nxt  = 1'b1;
          state_nxt = S_LN_C;
        end
      end
      S_LN_C: begin
        if (!mrun_r) begin
          dq_nxt    = {acc_r[NLN_BITS-1:0] + tmp_r[NLN_BITS-1:0], 16'd0};
          rem_nxt   = '0;
          it_nxt    = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = rem_ge ? rem_s - {1'b0, total_r} : rem_s;
        dq_nxt  = {dq_r[DVD_BITS-2:0], rem_ge};
        it_nxt  = it_r + 6'd1;
        if (it_r == 6'(DVD_BITS-1)) state_nxt = S_TIME;
      end
      S_TIME: begin
        time_nxt  = time_sum[TB] ? {TB{1'b1}} : time_sum[TB-1:0];
        acc_nxt   = '0;
        mc_nxt    = ACC_BITS'(total_r[31:0]);
        mp_nxt    = uc_r;
        mcnt_nxt  = 6'(MP_BITS);
        mrun_nxt  = 1'b1;
        state_nxt = S_THR_A;
      end
      S_THR_A: begin
        if (!mrun_r) begin
          tmp_nxt   = {32'd0, acc_r[63:32]};
          acc_nxt   = '0;
          mc_nxt    = ACC_BITS'(total_r[TOT_BITS-1:32]);
          mp_nxt    = uc_r;
          mcnt_nxt  = 6'(MP_BITS);
          mrun_nxt  = 1'b1;
          state_nxt = S_THR_B;
        end
      end
      S_THR_B: begin
        if (!mrun_r) begin
          tmp_nxt   = acc_r[63:0] + tmp_r;
          cum_nxt   = '0;
          j_nxt     = 3'd0;
          rxn_nxt   = srss_pkg::RXN_NONE;
          state_nxt = S_CHOOSE;
        end
      end
      S_CHOOSE: begin
        cum_nxt = cum_s;
        for (int i = 0; i < 6; i++) r_nxt[i] = r_r[i+1];
        r_nxt[6] = r_r[0];
        if (rxn_r == srss_pkg::RXN_NONE && cum_s > tmp_r) rxn_nxt = j_r + 3'd1;
        j_nxt = j_r + 3'd1;
        if (j_r == 3'd6) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (rxn_r)
          srss_pkg::RXN_FA: if (fv_r != '0) begin
            fv_nxt = fv_r - CB'(1); af_nxt = inc_cnt(af_r, 2'd1);
          end
          srss_pkg::RXN_FD: if (af_r != '0) begin
            af_nxt = af_r - CB'(1); fv_nxt = inc_cnt(fv_r, 2'd1);
          end
          srss_pkg::RXN_SA: if (sv_r != '0) begin
            sv_nxt = sv_r - CB'(1); as_nxt = inc_cnt(as_r, 2'd1);
          end
          srss_pkg::RXN_ER: if (as_r != '0) begin
            as_nxt = as_r - CB'(1); sv_nxt = inc_cnt(sv_r, 2'd1); mol_nxt = inc_mol(mol_r);
          end
          srss_pkg::RXN_DS: if (af_r != '0 && sv_r != '0) begin
            af_nxt = af_r - CB'(1); sv_nxt = sv_r - CB'(1);
            fv_nxt = inc_cnt(fv_r, 2'd1); as_nxt = inc_cnt(as_r, 2'd1);
          end
          srss_pkg::RXN_LHS: if (af_r != '0 && as_r != '0) begin
            af_nxt = af_r - CB'(1); as_nxt = as_r - CB'(1);
            sv_nxt = inc_cnt(sv_r, 2'd1); fv_nxt = inc_cnt(fv_r, 2'd1);
            mol_nxt = inc_mol(mol_r);
          end
          srss_pkg::RXN_LHF: if (af_r >= CB'(2)) begin
            af_nxt = af_r - CB'(2); fv_nxt = inc_cnt(fv_r, 2'd2); mol_nxt = inc_mol(mol_r);
          end
          default: ;
        endcase
        if (time_r >= stop_r) done_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.sim_time         = time_r;
          out_nxt.free_vacancies   = fv_r;
          out_nxt.free_adsorbed    = af_r;
          out_nxt.strong_vacancies = sv_r;
          out_nxt.strong_adsorbed  = as_r;
          out_nxt.molecules        = mol_r;
          out_nxt.reaction         = rxn_r;
          out_nxt.finished         = done_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      coef_r      <= '{default: '0};
      stop_r      <= '0;
      fv_r        <= '0;
      af_r        <= '0;
      sv_r        <= '0;
      as_r        <= '0;
      mol_r       <= '0;
      time_r      <= '0;
      done_r      <= 1'b1;
      mrun_r      <= 1'b0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coef_r      <= coef_nxt;
      stop_r      <= stop_nxt;
      fv_r        <= fv_nxt;
      af_r        <= af_nxt;
      sv_r        <= sv_nxt;
      as_r        <= as_nxt;
      mol_r       <= mol_nxt;
      time_r      <= time_nxt;
      done_r      <= done_nxt;
      mrun_r      <= mrun_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ut_r    <= ut_nxt;
    uc_r    <= uc_nxt;
    j_r     <= j_nxt;
    r_r     <= r_nxt;
    total_r <= total_nxt;
    mc_r    <= mc_nxt;
    acc_r   <= acc_nxt;
    mp_r    <= mp_nxt;
    mn_r    <= mn_nxt;
    lg_r    <= lg_nxt;
    sh_r    <= sh_nxt;
    it_r    <= it_nxt;
    tmp_r   <= tmp_nxt;
    cum_r   <= cum_nxt;
    dq_r    <= dq_nxt;
    rem_r   <= rem_nxt;
    rxn_r   <= rxn_nxt;
    out_r   <= out_nxt;
  end

endmodule
